// ===== design/led_level_store_and_apa102_framer_assert.svh =====
// Assertion macros for the LED level store and frame serializer.
`ifndef LED_LEVEL_STORE_AND_APA102_FRAMER_ASSERT_SVH
`define LED_LEVEL_STORE_AND_APA102_FRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// Flag a condition that must never hold while out of reset.
`define LEDFR_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ledfr: forbidden condition observed");
// Flag a consequent that fails in the cycle of its antecedent.
`define LEDFR_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ledfr: implication violated");
`else
`define LEDFR_NEVER(lbl, cond)
`define LEDFR_IMPLIES(lbl, ante, cons)
`endif
`endif

// ===== design/ledfr_pkg.sv =====
// Shared types and constants for the LED level store and frame serializer.
`timescale 1ns / 1ps
`default_nettype none
package ledfr_pkg;

  localparam int NUM_THEMES = 5;

  // Opcodes of the input transaction; the queue carries the same codes.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_EMIT  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_GLOBAL    = 3'd0;
  localparam logic [2:0] REG_AUTO      = 3'd1;
  localparam logic [2:0] REG_MIN       = 3'd2;
  localparam logic [2:0] REG_THEME0    = 3'd3;
  localparam logic [2:0] REG_THEME1    = 3'd4;
  localparam logic [2:0] REG_THEME2    = 3'd5;
  localparam logic [2:0] REG_THEME3    = 3'd6;
  localparam logic [2:0] REG_THEME4    = 3'd7;

  localparam logic [7:0] FULL_LEVEL    = 8'hFF;
  localparam logic [7:0] START_BYTE    = 8'h00;
  localparam logic [7:0] END_BYTE      = 8'hFF;
  localparam logic [7:0] HDR_MARK      = 8'hE0;
  localparam int         START_BYTES   = 4;

  localparam logic [7:0] RST_GLOBAL    = 8'd255;
  localparam logic       RST_AUTO      = 1'b1;
  localparam logic [7:0] RST_MIN       = 8'd10;

  typedef struct packed {
    logic [7:0]                       global_brightness;
    logic                             auto_brightness;
    logic [7:0]                       level_floor;
    logic [NUM_THEMES-1:0][23:0]      theme;
  } cfg_t;

  // One classified operation waiting for the back end.
  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  idx;
    logic [15:0] count;
    logic [2:0]  band;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ===== design/ledfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ledfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 84,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/ledfr_front.sv =====
// Front end: decode input transactions into queue entries, drop no-ops.
`timescale 1ns / 1ps
`default_nettype none
module ledfr_front #(
  parameter int LED_COUNT = 84
) (
  input  wire logic              accept,
  input  wire logic [1:0]        opcode,
  input  wire logic [6:0]        led_index,
  input  wire logic [15:0]       contribution_count,
  output logic                   push,
  output ledfr_pkg::op_t         entry
);
  import ledfr_pkg::*;

  logic idx_ok;
  logic keep;

  assign idx_ok = {1'b0, led_index} < 8'(LED_COUNT);

  // Drop the unused opcode and sets aimed past the last LED.
  always_comb begin
    case (opcode)
      OP_CLEAR, OP_EMIT: keep = 1'b1;
      OP_SET:            keep = idx_ok;
      default:           keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

  always_comb begin
    entry.kind  = opcode;
    entry.idx   = led_index;
    entry.count = contribution_count;
    if (contribution_count == 16'd0) begin
      entry.band = 3'd0;
    end else if (contribution_count <= 16'd3) begin
      entry.band = 3'd1;
    end else if (contribution_count <= 16'd6) begin
      entry.band = 3'd2;
    end else if (contribution_count <= 16'd9) begin
      entry.band = 3'd3;
    end else begin
      entry.band = 3'd4;
    end
  end

endmodule
`default_nettype wire

// ===== design/ledfr_queue.sv =====
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module ledfr_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire ledfr_pkg::op_t      wr_entry,
  input  wire logic                pop,
  output ledfr_pkg::op_t           head,
  output ledfr_pkg::q_status_t     status
);
  import ledfr_pkg::*;

  op_t        slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign head         = slot[rd_ptr];
  assign status.full  = fill == 2'd2;
  assign status.empty = fill == 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/ledfr_back.sv =====
// Back end: sequencer that runs clear, set and emit against the LED store.
`timescale 1ns / 1ps
`default_nettype none
module ledfr_back #(
  parameter int LED_COUNT = 84
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ledfr_pkg::cfg_t      cfg,
  input  wire logic                 q_empty,
  input  wire ledfr_pkg::op_t       q_head,
  output logic                      q_pop,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic [7:0]                frame_byte,
  output logic                      frame_last
);
  import ledfr_pkg::*;

  localparam int FRAME_LEN = START_BYTES + 4 * LED_COUNT + (LED_COUNT + 15) / 16;
  localparam int BODY_END  = START_BYTES + 4 * LED_COUNT;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam int ADDR_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LVL  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_WR   = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // floor(x / 255) for x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  logic [2:0]           state;
  logic [POS_W-1:0]     pos;
  logic [LED_COUNT-1:0] row_valid;

  // set path registers
  logic [ADDR_W-1:0]    cur_addr;
  logic [2:0]           cur_band;
  logic                 cur_zero;
  logic [23:0]          prod;
  logic [7:0]           lvl;
  logic [15:0]          red_prod;
  logic [15:0]          grn_prod;
  logic [15:0]          blu_prod;

  // emit path registers
  logic                 e_hdr;
  logic                 e_tail;
  logic [1:0]           e_part;
  logic                 e_last;
  logic                 rd_ok;
  logic [15:0]          hdr_prod;
  logic [7:0]           e_col;

  logic [POS_W-1:0]     rel;
  logic                 in_body;
  logic [ADDR_W-1:0]    raddr;
  logic [31:0]          rdata;
  logic                 we;
  logic [31:0]          wdata;
  logic [15:0]          cm1;
  logic [22:0]          lvl_sum;
  logic [7:0]           g;
  logic [23:0]          color;
  logic [7:0]           rd_lvl;
  logic [7:0]           rd_red;
  logic [7:0]           rd_grn;
  logic [7:0]           rd_blu;
  logic [7:0]           hdr_scaled;
  logic [7:0]           byte_next;
  logic                 out_free;

  assign rel     = pos - POS_W'(START_BYTES);
  assign in_body = (pos >= POS_W'(START_BYTES)) && (pos < POS_W'(BODY_END));
  assign raddr   = in_body ? ADDR_W'(rel[POS_W-1:2]) : '0;

  assign q_pop   = (state == ST_IDLE) && !q_empty;
  assign cm1     = q_head.count - 16'd1;
  assign lvl_sum = {15'b0, cfg.level_floor} + {1'b0, prod[23:2]};
  assign g       = (cfg.global_brightness < cfg.level_floor) ? cfg.level_floor
                                                              : cfg.global_brightness;
  assign color   = cfg.theme[cur_band];

  // Rows not written since the last clear read as black at full level.
  assign rd_lvl  = rd_ok ? rdata[7:0]   : FULL_LEVEL;
  assign rd_blu  = rd_ok ? rdata[15:8]  : 8'h00;
  assign rd_grn  = rd_ok ? rdata[23:16] : 8'h00;
  assign rd_red  = rd_ok ? rdata[31:24] : 8'h00;

  assign we      = state == ST_WR;
  assign wdata   = {div255(red_prod), div255(grn_prod), div255(blu_prod), lvl};

  assign hdr_scaled = div255(hdr_prod);
  assign out_free   = !out_valid || !out_stall;

  always_comb begin
    if (e_hdr) begin
      byte_next = START_BYTE;
    end else if (e_tail) begin
      byte_next = END_BYTE;
    end else if (e_part == 2'd0) begin
      byte_next = HDR_MARK | {3'b000, hdr_scaled[7:3]};
    end else begin
      byte_next = e_col;
    end
  end

  ledfr_ram #(
    .WIDTH (32),
    .DEPTH (LED_COUNT),
    .AW    (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (cur_addr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    rd_ok <= row_valid[raddr];
    case (state)
      ST_IDLE: begin
        cur_addr <= ADDR_W'(q_head.idx);
        cur_band <= q_head.band;
        cur_zero <= q_head.count == 16'd0;
        prod     <= cm1 * (FULL_LEVEL - cfg.level_floor);
        e_hdr    <= pos < POS_W'(START_BYTES);
        e_tail   <= pos >= POS_W'(BODY_END);
        e_part   <= rel[1:0];
        e_last   <= pos == POS_W'(FRAME_LEN - 1);
      end
      ST_LVL: begin
        if (!cfg.auto_brightness) begin
          lvl <= FULL_LEVEL;
        end else if (cur_zero) begin
          lvl <= 8'd0;
        end else if (lvl_sum > 23'(FULL_LEVEL)) begin
          lvl <= FULL_LEVEL;
        end else begin
          lvl <= lvl_sum[7:0];
        end
      end
      ST_MUL: begin
        red_prod <= color[23:16] * lvl;
        grn_prod <= color[15:8] * lvl;
        blu_prod <= color[7:0] * lvl;
      end
      ST_RD: begin
        hdr_prod <= rd_lvl * g;
        case (e_part)
          2'd1:    e_col <= rd_blu;
          2'd2:    e_col <= rd_grn;
          default: e_col <= rd_red;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_free && state == ST_OUT) begin
      frame_byte <= byte_next;
      frame_last <= e_last;
    end
  end

  // Control: sequencer state, frame position, row valid bits, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            case (q_head.kind)
              OP_CLEAR: row_valid <= '0;
              OP_SET:   state     <= ST_LVL;
              OP_EMIT:  state     <= ST_RD;
              default:  state     <= ST_IDLE;
            endcase
          end
        end
        ST_LVL: state <= ST_MUL;
        ST_MUL: state <= ST_WR;
        ST_WR: begin
          row_valid[cur_addr] <= 1'b1;
          state               <= ST_IDLE;
        end
        ST_RD: state <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            pos   <= e_last ? '0 : pos + POS_W'(1);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/led_level_store_and_apa102_framer.sv =====
// Top level: LED colour/level store with an APA102 frame byte serializer.
// Clear is done in the idle state; set LED goes through level, multiply, write;
// emit goes through read and output, plus any wait on out_stall.
// The back-end sequencer and one store write and one read port set the rate.
// rst (synchronous) clears the queue, store valid bits, frame position, output
// valid, and reloads the configuration registers.
`timescale 1ns / 1ps
`default_nettype none
`include "led_level_store_and_apa102_framer_assert.svh"
module led_level_store_and_apa102_framer #(
  parameter int LED_COUNT = 84
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input transaction channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [6:0]  led_index,
  input  wire logic [15:0] contribution_count,
  // result transaction channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       frame_byte,
  output logic             frame_last,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import ledfr_pkg::*;

  cfg_t      cfg;
  op_t       fe_entry;
  op_t       q_head;
  q_status_t q_status;
  logic      fe_push;
  logic      q_pop;
  logic      in_accept;

  // The register file always takes a write; the block is idle by contract.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.global_brightness <= RST_GLOBAL;
      cfg.auto_brightness   <= RST_AUTO;
      cfg.level_floor       <= RST_MIN;
      cfg.theme             <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GLOBAL: cfg.global_brightness <= cfg_data[7:0];
        REG_AUTO:   cfg.auto_brightness   <= cfg_data[0];
        REG_MIN:    cfg.level_floor       <= cfg_data[7:0];
        REG_THEME0: cfg.theme[0]          <= cfg_data;
        REG_THEME1: cfg.theme[1]          <= cfg_data;
        REG_THEME2: cfg.theme[2]          <= cfg_data;
        REG_THEME3: cfg.theme[3]          <= cfg_data;
        REG_THEME4: cfg.theme[4]          <= cfg_data;
        default:    cfg.theme[0]          <= cfg.theme[0];
      endcase
    end
  end

  // Hold off the input side only when the queue has no room; results waiting
  // at the output never block the front end directly.
  assign in_stall  = q_status.full;
  assign in_accept = in_valid && !in_stall;

  ledfr_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .accept             (in_accept),
    .opcode             (opcode),
    .led_index          (led_index),
    .contribution_count (contribution_count),
    .push               (fe_push),
    .entry              (fe_entry)
  );

  ledfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fe_push),
    .wr_entry (fe_entry),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  // The back end drains the queue in order, so a set or clear is always
  // visible to the emit transactions that follow it.
  ledfr_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_status.empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .frame_byte (frame_byte),
    .frame_last (frame_last)
  );

  // Never pop an empty queue, never push into a full one.
  `LEDFR_NEVER(a_pop_empty, q_pop && q_status.empty)
  `LEDFR_NEVER(a_push_full, fe_push && q_status.full)
  // The closing byte of every frame is an end-frame byte.
  `LEDFR_IMPLIES(a_last_is_end, out_valid && frame_last, frame_byte == END_BYTE)

endmodule
`default_nettype wire

// ===== bench/tb_led_level_store_and_apa102_framer.sv =====
// Self-checking bench for the LED level store and APA102 frame serializer.
`timescale 1ns / 1ps
module tb_led_level_store_and_apa102_framer;
  import ledfr_pkg::*;

  localparam int LED_COUNT      = 84;
  localparam int END_BYTES      = (LED_COUNT + 15) / 16;
  localparam int FRAME_LEN      = START_BYTES + 4 * LED_COUNT + END_BYTES;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 238;
  // The opcode space has one unused code; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [6:0]  idx;
    logic [15:0] cnt;
  } led_op_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = OP_CLEAR;
  logic [6:0]  led_index = '0;
  logic [15:0] contribution_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  frame_byte;
  logic        frame_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_GLOBAL;
  logic [23:0] cfg_data = '0;

  led_level_store_and_apa102_framer #(.LED_COUNT(LED_COUNT)) dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .opcode             (opcode),
    .led_index          (led_index),
    .contribution_count (contribution_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .frame_byte         (frame_byte),
    .frame_last         (frame_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the block: register file, LED store and frame pointer.
  logic [7:0]  cfg_global = RST_GLOBAL;
  logic        cfg_auto   = RST_AUTO;
  logic [7:0]  cfg_min    = RST_MIN;
  logic [23:0] cfg_theme [NUM_THEMES];
  logic [7:0]  led_red   [LED_COUNT];
  logic [7:0]  led_green [LED_COUNT];
  logic [7:0]  led_blue  [LED_COUNT];
  logic [7:0]  led_level [LED_COUNT];
  int unsigned frame_pos = 0;

  led_op_t     pending_ops [$];   // items the driver still has to present
  frame_beat_t frame_due   [$];   // frame bytes owed by the block, oldest first
  int          fail_count = 0;
  int          burst_left = 0;
  int          gap_left   = 0;
  int          stall_mode = 0;
  int          mode_left  = 0;
  int          stall_tick = 0;
  int          idle_cycles = 0;

  // Black at full level, as after reset or a clear transaction.
  task automatic blank_leds();
    for (int i = 0; i < LED_COUNT; i++) begin
      led_red[i]   = '0;
      led_green[i] = '0;
      led_blue[i]  = '0;
      led_level[i] = FULL_LEVEL;
    end
  endtask

  // Apply one accepted transaction to the shadow and queue the byte an emit owes.
  task automatic advance_led_model(input logic [1:0] op, input logic [6:0] idx,
                                   input logic [15:0] cnt);
    int unsigned lv, mn, gl, hl, c32, pos, led;
    logic [23:0] rgb;
    frame_beat_t beat;
    mn  = cfg_min;
    c32 = cnt;
    case (op)
      OP_CLEAR: begin
        blank_leds();
      end
      OP_SET: begin
        // Out-of-range LEDs leave the store untouched.
        if (idx < LED_COUNT) begin
          if (!cfg_auto) lv = FULL_LEVEL;
          else if (c32 == 0) lv = 0;
          else begin
            lv = mn + ((c32 - 1) * (FULL_LEVEL - mn)) / 4;
            if (lv > FULL_LEVEL) lv = FULL_LEVEL;
          end
          if (c32 == 0) rgb = cfg_theme[0];
          else if (c32 <= 3) rgb = cfg_theme[1];
          else if (c32 <= 6) rgb = cfg_theme[2];
          else if (c32 <= 9) rgb = cfg_theme[3];
          else rgb = cfg_theme[4];
          led_red[idx]   = 8'((32'(rgb[23:16]) * lv) / FULL_LEVEL);
          led_green[idx] = 8'((32'(rgb[15:8]) * lv) / FULL_LEVEL);
          led_blue[idx]  = 8'((32'(rgb[7:0]) * lv) / FULL_LEVEL);
          led_level[idx] = 8'(lv);
        end
      end
      OP_EMIT: begin
        pos = (frame_pos >= FRAME_LEN) ? 0 : frame_pos;
        if (pos < START_BYTES) beat.data = START_BYTE;
        else if (pos >= START_BYTES + 4 * LED_COUNT) beat.data = END_BYTE;
        else begin
          led = (pos - START_BYTES) / 4;
          case ((pos - START_BYTES) % 4)
            0: begin
              gl = (cfg_global < cfg_min) ? cfg_min : cfg_global;
              hl = (32'(led_level[led]) * gl) / FULL_LEVEL;
              beat.data = HDR_MARK | 8'((hl >> 3) & 32'h1F);
            end
            1: beat.data = led_blue[led];
            2: beat.data = led_green[led];
            default: beat.data = led_red[led];
          endcase
        end
        beat.last = (pos == FRAME_LEN - 1);
        frame_due.push_back(beat);
        frame_pos = (pos + 1 >= FRAME_LEN) ? 0 : pos + 1;
      end
      default: ;  // unused opcode: no effect, no result
    endcase
  endtask

  // Input driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin : driver
    led_op_t nxt;
    logic go;
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) advance_led_model(opcode, led_index, contribution_count);
      // Hold the payload while stalled; otherwise pick the next beat.
      if (!(in_valid && in_stall)) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          nxt = pending_ops.pop_front();
          go  = 1'b1;
          opcode             <= nxt.op;
          led_index          <= nxt.idx;
          contribution_count <= nxt.cnt;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
        in_valid <= go;
      end
    end
  end

  // Output monitor: check each frame byte, then drive the stall pattern.
  always @(posedge clk) begin : monitor
    frame_beat_t want;
    logic hold;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode = 0;
      mode_left  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_due.size() == 0) begin
          $error("frame_byte: no transaction expected, got %02h", frame_byte);
          fail_count++;
        end else begin
          want = frame_due.pop_front();
          if (frame_byte !== want.data) begin
            $error("frame_byte: expected %02h, got %02h", want.data, frame_byte);
            fail_count++;
          end
          if (frame_last !== want.last) begin
            $error("frame_last: expected %0b, got %0b", want.last, frame_last);
            fail_count++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: hold = 1'b0;
        1: hold = ($urandom_range(0, 3) == 0);
        2: hold = ($urandom_range(0, 3) != 0);
        default: hold = ((stall_tick % 5) < 2);
      endcase
      stall_tick++;
      out_stall <= hold;
    end
  end

  // Watchdog: end the run if no channel moves a transaction for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // One register write; the shadow takes the value at the handshake.
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GLOBAL: cfg_global = data[7:0];
      REG_AUTO:   cfg_auto   = data[0];
      REG_MIN:    cfg_min    = data[7:0];
      default:    cfg_theme[idx - REG_THEME0] = data;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_op(input logic [1:0] op, input logic [6:0] idx,
                          input logic [15:0] cnt);
    led_op_t it;
    it.op  = op;
    it.idx = idx;
    it.cnt = cnt;
    pending_ops.push_back(it);
  endtask

  // Let everything drain: all items taken, all bytes seen, back end quiet.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_ops.size() != 0 || in_valid || frame_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the whole register file.
  task automatic program_regs(input logic [7:0] g, input logic a, input logic [7:0] m,
                              input logic [23:0] th [NUM_THEMES]);
    write_reg(REG_GLOBAL, {16'd0, g});
    write_reg(REG_AUTO, {23'd0, a});
    write_reg(REG_MIN, {16'd0, m});
    for (int k = 0; k < NUM_THEMES; k++) write_reg(3'(REG_THEME0 + k), th[k]);
  endtask

  initial begin : stimulus
    logic [23:0] th [NUM_THEMES];
    logic [7:0]  g, m;
    logic        a;
    int          r, k;
    logic [1:0]  op;
    logic [6:0]  idx;
    logic [15:0] cnt;

    for (int i = 0; i < NUM_THEMES; i++) cfg_theme[i] = '0;
    blank_leds();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed phase: every colour band, both index limits, unused opcode,
    // clear and set in the middle of a frame.
    th[0] = 24'h102030; th[1] = 24'hFFFFFF; th[2] = 24'h00FF00;
    th[3] = 24'h0000FF; th[4] = 24'hFF0000;
    program_regs(8'd255, 1'b1, 8'd10, th);
    queue_op(OP_CLEAR, 7'd0, 16'd0);
    queue_op(OP_EMIT, 7'd0, 16'd0);
    queue_op(OP_EMIT, 7'd127, 16'hFFFF);
    queue_op(OP_SET, 7'd0, 16'd0);
    queue_op(OP_SET, 7'd1, 16'd1);
    queue_op(OP_SET, 7'd2, 16'd3);
    queue_op(OP_SET, 7'd3, 16'd4);
    queue_op(OP_SET, 7'd4, 16'd6);
    queue_op(OP_SET, 7'd5, 16'd7);
    queue_op(OP_SET, 7'd6, 16'd9);
    queue_op(OP_SET, 7'd7, 16'd10);
    queue_op(OP_SET, 7'(LED_COUNT - 1), 16'hFFFF);
    queue_op(OP_SET, 7'(LED_COUNT), 16'd5);
    queue_op(OP_SET, 7'd127, 16'hFFFF);
    queue_op(OP_UNUSED, 7'd127, 16'hFFFF);
    for (int i = 0; i < 6; i++) queue_op(OP_EMIT, 7'd0, 16'd0);
    queue_op(OP_CLEAR, 7'd0, 16'd0);
    queue_op(OP_EMIT, 7'd0, 16'd0);
    queue_op(OP_SET, 7'd1, 16'd2);
    queue_op(OP_EMIT, 7'd0, 16'd0);
    queue_op(OP_EMIT, 7'd0, 16'd0);
    wait_drained();

    // Random phases, each under its own register setting.
    for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
      for (int i = 0; i < NUM_THEMES; i++) th[i] = 24'($urandom);
      g = 8'($urandom);
      m = 8'($urandom);
      a = 1'b1;
      case (ph)
        1: begin g = 8'd0; m = 8'd0; end
        2: begin
          g = 8'd255; m = 8'd255;
          for (int i = 0; i < NUM_THEMES; i++) th[i] = 24'hFFFFFF;
        end
        3: a = 1'b0;
        4: begin
          g = 8'd0; m = 8'd255;
          for (int i = 0; i < NUM_THEMES - 1; i++) th[i] = 24'h000000;
        end
        5: a = 1'($urandom);
        default: begin
          g = 8'd255; m = 8'd0;
          th[0] = 24'hFFFFFF; th[4] = 24'hFFFFFF;
        end
      endcase
      program_regs(g, a, m, th);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r   = $urandom_range(0, 99);
        idx = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(LED_COUNT, 127))
                                          : 7'($urandom_range(0, LED_COUNT - 1));
        k   = $urandom_range(0, 9);
        if (k < 6) cnt = 16'($urandom_range(0, 12));
        else if (k < 8) cnt = 16'($urandom_range(0, 65535));
        else if (k == 8) cnt = 16'hFFFF;
        else cnt = 16'($urandom_range(13, 40));
        if (r < 58) begin
          op = OP_EMIT;
          idx = 7'($urandom);
          cnt = 16'($urandom);
        end else if (r < 94) op = OP_SET;
        else if (r < 96) op = OP_CLEAR;
        else begin
          op = OP_UNUSED;
          idx = 7'($urandom);
          cnt = 16'($urandom);
        end
        // End every phase on an emit so its byte marks the back end as done.
        if (n == PHASE_ITEMS - 1) op = OP_EMIT;
        queue_op(op, idx, cnt);
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ledfr_pkg.sv
design/ledfr_ram.sv
design/ledfr_front.sv
design/ledfr_queue.sv
design/ledfr_back.sv
design/led_level_store_and_apa102_framer.sv
bench/tb_led_level_store_and_apa102_framer.sv
